// ----- rtl/core/tisl_pkg.sv -----
// tisl_pkg: shared constants, command and status codes, and types for the
// pointing schedule lookup unit. Used by tisl_store, tisl_match and the top level.
package tisl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int TIME_W = 32;
    localparam int RA_W   = 29;
    localparam int DEC_W  = 28;
    localparam int AGE_W  = 31;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_TOO_OLD = 2'd1;
    localparam logic [1:0] ST_NONPOS  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_AGE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_RA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_DEC    = 3'd4;

    localparam logic [AGE_W-1:0] SKIP_AGE_RESET = 31'd86400;
    localparam int ONE_DAY = 24 * 3600;
    localparam logic signed [TIME_W-1:0] OPEN_END_LIMIT = 32'sd10;
    localparam logic [TIME_W-1:0] TIME_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [TIME_W-1:0] start;
        logic [RA_W-1:0]          ra;
        logic signed [DEC_W-1:0]  dec;
    } t_entry;

    typedef struct packed {
        logic              ent_we;
        logic [IDX_W-1:0]  ent_addr;
        t_entry            ent_data;
        logic              end_we;
        logic [IDX_W-1:0]  end_addr;
        logic [TIME_W-1:0] end_data;
    } t_store_wr;

    typedef struct packed {
        logic contain;
        logic gap;
    } t_match;

endpackage

// ----- rtl/core/tisl_store.sv -----
// tisl_store: entry memory (start, position) and end time memory, one read
// address, registered read data. Depends on tisl_pkg.
module tisl_store (
    input  logic                         i_clk,
    input  logic [tisl_pkg::IDX_W-1:0]   i_rd_addr,
    input  tisl_pkg::t_store_wr          i_wr,
    output tisl_pkg::t_entry             o_rd_entry,
    output logic [tisl_pkg::TIME_W-1:0]  o_rd_end
);

    tisl_pkg::t_entry            r_ent_mem [tisl_pkg::TABLE_DEPTH];
    logic [tisl_pkg::TIME_W-1:0] r_end_mem [tisl_pkg::TABLE_DEPTH];
    tisl_pkg::t_entry            r_rd_entry;
    logic [tisl_pkg::TIME_W-1:0] r_rd_end;

    always_ff @(posedge i_clk) begin
        if (i_wr.ent_we) begin
            r_ent_mem[i_wr.ent_addr] <= i_wr.ent_data;
        end
        r_rd_entry <= r_ent_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.end_we) begin
            r_end_mem[i_wr.end_addr] <= i_wr.end_data;
        end
        r_rd_end <= r_end_mem[i_rd_addr];
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_end   = r_rd_end;

endmodule

// ----- rtl/core/tisl_match.sv -----
// tisl_match: interval checks for one scanned entry: containment with the
// early margin, and the gap up to the next newer entry. Depends on tisl_pkg.
module tisl_match (
    input  logic signed [tisl_pkg::TIME_W-1:0] i_time,
    input  logic [tisl_pkg::AGE_W-1:0]         i_margin,
    input  logic signed [tisl_pkg::TIME_W-1:0] i_start,
    input  logic signed [tisl_pkg::TIME_W-1:0] i_end,
    input  logic signed [tisl_pkg::TIME_W-1:0] i_next_start,
    input  logic                               i_has_next,
    output tisl_pkg::t_match                   o_match
);

    logic signed [tisl_pkg::TIME_W+1:0] low_bound;
    logic signed [tisl_pkg::TIME_W+1:0] time_ext;

    // start minus margin can fall below the 32-bit range
    assign low_bound = $signed({{2{i_start[tisl_pkg::TIME_W-1]}}, i_start})
                     - $signed({3'b000, i_margin});
    assign time_ext  = $signed({{2{i_time[tisl_pkg::TIME_W-1]}}, i_time});

    assign o_match.contain = (time_ext >= low_bound) && (i_time <= i_end);
    assign o_match.gap     = i_has_next && (i_time >= i_end) && (i_time <= i_next_start);

endmodule

// ----- rtl/core/time_interval_schedule_lookup_unit.sv -----
// Pointing schedule lookup unit: command sequencer, configuration registers
// and result register around tisl_store and tisl_match. Depends on tisl_pkg.
//
// Input channel: i_in_valid / o_in_stall with command, event time, position
// and current time. One result item per command on o_out_valid / i_out_stall.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// writes are expected only while no command is in flight.
// From accept to result: clear and finish go S_CMD, S_DONE; a storing append
// also passes S_APP2, which zeroes its end time; a query in fixed-target mode
// or on an empty table goes S_CMD, S_DONE; a scanning query visits entries
// in S_SCAN from the newest one down (at most the entry count), then S_FALL
// for the first/last fallback if none matches. The scan reads one entry per
// cycle through the single read port of the table memories, all 256 when full.
// The next item is accepted in the cycle after the result has moved into the
// output register; that register holds a finished result while the receiver
// stalls, and the sequencer waits only if a second result is ready first.
// Reset clears the entry count, the sequencer, the output valid and the
// configuration registers (skip age 86400 s, the rest zero); table memories
// are not cleared and entries are only read below the entry count.
module time_interval_schedule_lookup_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_command,
    input  logic signed [tisl_pkg::TIME_W-1:0]     i_event_time,
    input  logic [tisl_pkg::RA_W-1:0]              i_position_ra,
    input  logic signed [tisl_pkg::DEC_W-1:0]      i_position_dec,
    input  logic signed [tisl_pkg::TIME_W-1:0]     i_current_time,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_hit,
    output logic [tisl_pkg::RA_W-1:0]              o_result_ra,
    output logic signed [tisl_pkg::DEC_W-1:0]      o_result_dec,
    output logic signed [tisl_pkg::TIME_W-1:0]     o_effective_time,
    output logic [1:0]                             o_load_status,
    output logic [tisl_pkg::CNT_W-1:0]             o_entries_held,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tisl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tisl_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CMD  = 6'b000010,
        S_APP2 = 6'b000100,
        S_SCAN = 6'b001000,
        S_FALL = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [tisl_pkg::CNT_W-1:0] r_count, n_count;
    logic [tisl_pkg::IDX_W-1:0] r_idx;
    logic                       r_first;

    // configuration
    logic [tisl_pkg::AGE_W-1:0]         r_skip_age;
    logic [tisl_pkg::AGE_W-1:0]         r_early_margin;
    logic                               r_fixed_mode;
    logic [tisl_pkg::RA_W-1:0]          r_fixed_ra;
    logic signed [tisl_pkg::DEC_W-1:0]  r_fixed_dec;

    // accepted item
    logic [1:0]                         r_cmd;
    logic signed [tisl_pkg::TIME_W-1:0] r_t;
    logic [tisl_pkg::RA_W-1:0]          r_ra;
    logic signed [tisl_pkg::DEC_W-1:0]  r_dec;
    logic signed [tisl_pkg::TIME_W-1:0] r_now;

    // scan state
    tisl_pkg::t_entry r_last;
    tisl_pkg::t_entry r_nx;

    // working result
    logic                               r_hit;
    logic [tisl_pkg::RA_W-1:0]          r_res_ra;
    logic signed [tisl_pkg::DEC_W-1:0]  r_res_dec;
    logic signed [tisl_pkg::TIME_W-1:0] r_eff;
    logic [1:0]                         r_status;

    // output register
    logic                               r_out_valid;
    logic                               r_out_hit;
    logic [tisl_pkg::RA_W-1:0]          r_out_ra;
    logic signed [tisl_pkg::DEC_W-1:0]  r_out_dec;
    logic signed [tisl_pkg::TIME_W-1:0] r_out_eff;
    logic [1:0]                         r_out_status;
    logic [tisl_pkg::CNT_W-1:0]         r_out_count;

    logic                               in_accept;
    logic                               out_free;
    logic [tisl_pkg::IDX_W-1:0]         last_idx;
    logic [tisl_pkg::IDX_W-1:0]         rd_addr;
    tisl_pkg::t_store_wr                wr;
    tisl_pkg::t_entry                   rd_entry;
    logic [tisl_pkg::TIME_W-1:0]        rd_end;
    tisl_pkg::t_match                   match;
    logic signed [tisl_pkg::TIME_W+1:0] age;
    logic                               too_old;
    logic                               nonpos;
    logic                               full;
    logic                               app_store;
    logic [tisl_pkg::TIME_W:0]          fin_sum;
    logic [tisl_pkg::TIME_W-1:0]        fin_end;
    logic                               open_end;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign last_idx = tisl_pkg::IDX_W'(r_count - tisl_pkg::CNT_W'(1));
    // in idle and dispatch the newest entry is read, so a scan starts with it
    assign rd_addr  = (r_state == S_IDLE || r_state == S_CMD)
                    ? last_idx : r_idx - tisl_pkg::IDX_W'(1);

    assign age = $signed({{2{r_now[tisl_pkg::TIME_W-1]}}, r_now})
               - $signed({{2{r_t[tisl_pkg::TIME_W-1]}}, r_t});
    assign too_old   = (r_skip_age != '0) && (age > $signed({3'b000, r_skip_age}));
    assign nonpos    = r_t[tisl_pkg::TIME_W-1] || (r_t == '0);
    assign full      = (r_count == tisl_pkg::CNT_W'(tisl_pkg::TABLE_DEPTH));
    assign app_store = !too_old && !nonpos && !full;

    assign fin_sum  = {rd_entry.start[tisl_pkg::TIME_W-1], rd_entry.start}
                    + (tisl_pkg::TIME_W + 1)'(tisl_pkg::ONE_DAY);
    assign fin_end  = ($signed(fin_sum) > $signed({1'b0, tisl_pkg::TIME_MAX}))
                    ? tisl_pkg::TIME_MAX : fin_sum[tisl_pkg::TIME_W-1:0];
    assign open_end = $signed(rd_end) < tisl_pkg::OPEN_END_LIMIT;

    tisl_store u_store (
        .i_clk      (i_clk),
        .i_rd_addr  (rd_addr),
        .i_wr       (wr),
        .o_rd_entry (rd_entry),
        .o_rd_end   (rd_end)
    );

    tisl_match u_match (
        .i_time       (r_t),
        .i_margin     (r_early_margin),
        .i_start      (rd_entry.start),
        .i_end        ($signed(rd_end)),
        .i_next_start (r_nx.start),
        .i_has_next   (!r_first),
        .o_match      (match)
    );

    // memory writes
    always_comb begin
        wr = '0;
        unique case (r_state)
            S_CMD: begin
                if (r_cmd == tisl_pkg::CMD_APPEND && !too_old) begin
                    // previous entry closes even when this record is rejected
                    if (r_count != '0) begin
                        wr.end_we   = 1'b1;
                        wr.end_addr = last_idx;
                        wr.end_data = r_t;
                    end
                    if (app_store) begin
                        wr.ent_we   = 1'b1;
                        wr.ent_addr = r_count[tisl_pkg::IDX_W-1:0];
                        wr.ent_data = '{start: r_t, ra: r_ra, dec: r_dec};
                    end
                end else if (r_cmd == tisl_pkg::CMD_FINISH && r_count != '0 && open_end) begin
                    wr.end_we   = 1'b1;
                    wr.end_addr = last_idx;
                    wr.end_data = fin_end;
                end
            end
            S_APP2: begin
                // count already includes the new entry
                wr.end_we   = 1'b1;
                wr.end_addr = last_idx;
                wr.end_data = '0;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_CMD;
            end
            S_CMD: begin
                unique case (r_cmd)
                    tisl_pkg::CMD_CLEAR: begin
                        n_count = '0;
                        n_state = S_DONE;
                    end
                    tisl_pkg::CMD_APPEND: begin
                        if (app_store) begin
                            n_count = r_count + tisl_pkg::CNT_W'(1);
                            n_state = S_APP2;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    tisl_pkg::CMD_FINISH: n_state = S_DONE;
                    default: begin
                        n_state = (!r_fixed_mode && r_count != '0) ? S_SCAN : S_DONE;
                    end
                endcase
            end
            S_APP2: n_state = S_DONE;
            S_SCAN: begin
                if (match.contain || match.gap) n_state = S_DONE;
                else if (r_idx == '0)           n_state = S_FALL;
            end
            S_FALL: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_age     <= tisl_pkg::SKIP_AGE_RESET;
            r_early_margin <= '0;
            r_fixed_mode   <= 1'b0;
            r_fixed_ra     <= '0;
            r_fixed_dec    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tisl_pkg::CFG_SKIP_AGE:     r_skip_age     <= i_cfg_data[tisl_pkg::AGE_W-1:0];
                tisl_pkg::CFG_EARLY_MARGIN: r_early_margin <= i_cfg_data[tisl_pkg::AGE_W-1:0];
                tisl_pkg::CFG_FIXED_MODE:   r_fixed_mode   <= i_cfg_data[0];
                tisl_pkg::CFG_FIXED_RA:     r_fixed_ra     <= i_cfg_data[tisl_pkg::RA_W-1:0];
                tisl_pkg::CFG_FIXED_DEC:    r_fixed_dec    <= $signed(i_cfg_data[tisl_pkg::DEC_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // item, scan and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_command;
            r_t   <= i_event_time;
            r_ra  <= i_position_ra;
            r_dec <= i_position_dec;
            r_now <= i_current_time;
        end
        case (r_state)
            S_CMD: begin
                r_hit     <= 1'b0;
                r_res_ra  <= '0;
                r_res_dec <= '0;
                r_eff     <= '0;
                r_status  <= tisl_pkg::ST_STORED;
                r_idx     <= last_idx;
                r_first   <= 1'b1;
                case (r_cmd)
                    tisl_pkg::CMD_APPEND: begin
                        if (too_old)     r_status <= tisl_pkg::ST_TOO_OLD;
                        else if (nonpos) r_status <= tisl_pkg::ST_NONPOS;
                        else if (full)   r_status <= tisl_pkg::ST_FULL;
                    end
                    tisl_pkg::CMD_FINISH: r_hit <= (r_count != '0);
                    tisl_pkg::CMD_QUERY: begin
                        if (r_fixed_mode) begin
                            r_hit     <= 1'b1;
                            r_res_ra  <= r_fixed_ra;
                            r_res_dec <= r_fixed_dec;
                            r_eff     <= r_t;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                r_first <= 1'b0;
                if (r_first) r_last <= rd_entry;
                r_nx  <= rd_entry;
                r_idx <= r_idx - tisl_pkg::IDX_W'(1);
                if (match.contain) begin
                    r_hit     <= 1'b1;
                    r_res_ra  <= rd_entry.ra;
                    r_res_dec <= rd_entry.dec;
                    r_eff     <= r_t;
                end else if (match.gap) begin
                    // the gap belongs to the newer neighbor
                    r_hit     <= 1'b1;
                    r_res_ra  <= r_nx.ra;
                    r_res_dec <= r_nx.dec;
                    r_eff     <= r_t;
                end
            end
            S_FALL: begin
                // r_nx now holds the oldest entry; after-last wins over before-first
                if ($signed(r_t) > $signed(r_last.start)) begin
                    r_hit     <= 1'b1;
                    r_res_ra  <= r_last.ra;
                    r_res_dec <= r_last.dec;
                    r_eff     <= r_last.start;
                end else if ($signed(r_t) < $signed(r_nx.start)) begin
                    r_hit     <= 1'b1;
                    r_res_ra  <= r_nx.ra;
                    r_res_dec <= r_nx.dec;
                    r_eff     <= r_nx.start;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_hit    <= r_hit;
                    r_out_ra     <= r_res_ra;
                    r_out_dec    <= r_res_dec;
                    r_out_eff    <= r_eff;
                    r_out_status <= r_status;
                    r_out_count  <= r_count;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_out_hit;
    assign o_result_ra      = r_out_ra;
    assign o_result_dec     = r_out_dec;
    assign o_effective_time = r_out_eff;
    assign o_load_status    = r_out_status;
    assign o_entries_held   = r_out_count;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tisl_pkg::CNT_W'(tisl_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_CMD))
        else $error("accepted item not dispatched");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_idx} < r_count))
        else $error("scan index beyond stored entries");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |-> $past(r_state == S_CMD))
        else $error("entry count changed outside dispatch");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(o_out_valid)) |-> $past(r_state == S_DONE))
        else $error("result valid without a finished item");
`endif

endmodule

// ----- test/tb_time_interval_schedule_lookup_unit.sv -----
`timescale 1ns / 100ps
// Self-checking bench for time_interval_schedule_lookup_unit: a directed table of commands,
// then random load/query phases under changing register settings; typed rows are checked
// against given values, others against a schedule predictor. Needs tisl_pkg and the RTL.
module tb_time_interval_schedule_lookup_unit;

    localparam int RA_MAX         = 377487360;
    localparam int DEC_MAX        = 94371840;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                        hit;
        logic [tisl_pkg::RA_W-1:0]   ra;
        logic [tisl_pkg::DEC_W-1:0]  dec;
        logic [tisl_pkg::TIME_W-1:0] eff;
        logic [1:0]                  status;
        logic [tisl_pkg::CNT_W-1:0]  held;
    } t_lookup_out;

    typedef struct {
        logic [1:0] cmd;
        int         t;
        int         ra;
        int         dec;
        int         now;
        bit         typed;
        logic       hit;
        logic [1:0] status;
        int         held;
    } t_plan_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic [1:0]                         i_command = tisl_pkg::CMD_CLEAR;
    logic signed [tisl_pkg::TIME_W-1:0] i_event_time = '0;
    logic [tisl_pkg::RA_W-1:0]          i_position_ra = '0;
    logic signed [tisl_pkg::DEC_W-1:0]  i_position_dec = '0;
    logic signed [tisl_pkg::TIME_W-1:0] i_current_time = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic                               o_hit;
    logic [tisl_pkg::RA_W-1:0]          o_result_ra;
    logic signed [tisl_pkg::DEC_W-1:0]  o_result_dec;
    logic signed [tisl_pkg::TIME_W-1:0] o_effective_time;
    logic [1:0]                         o_load_status;
    logic [tisl_pkg::CNT_W-1:0]         o_entries_held;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [tisl_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [tisl_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;

    // predicted schedule table and registers
    int                         sched_start [tisl_pkg::TABLE_DEPTH];
    int                         sched_end   [tisl_pkg::TABLE_DEPTH];
    logic [tisl_pkg::RA_W-1:0]  sched_ra    [tisl_pkg::TABLE_DEPTH];
    logic [tisl_pkg::DEC_W-1:0] sched_dec   [tisl_pkg::TABLE_DEPTH];
    int                         sched_count = 0;
    logic [tisl_pkg::AGE_W-1:0] cfg_skip_age = tisl_pkg::SKIP_AGE_RESET;
    logic [tisl_pkg::AGE_W-1:0] cfg_early_margin = '0;
    logic                       cfg_fixed_mode = 1'b0;
    logic [tisl_pkg::RA_W-1:0]  cfg_fixed_ra = '0;
    logic [tisl_pkg::DEC_W-1:0] cfg_fixed_dec = '0;

    t_lookup_out pending_results [$];
    t_plan_row   directed_plan [$];
    bit          drv_typed = 1'b0;
    t_lookup_out drv_exp = '0;
    bit          in_quiet = 1'b0;
    int          items_sent = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    time_interval_schedule_lookup_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_event_time     (i_event_time),
        .i_position_ra    (i_position_ra),
        .i_position_dec   (i_position_dec),
        .i_current_time   (i_current_time),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_hit            (o_hit),
        .o_result_ra      (o_result_ra),
        .o_result_dec     (o_result_dec),
        .o_effective_time (o_effective_time),
        .o_load_status    (o_load_status),
        .o_entries_held   (o_entries_held),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic int rand_dec();
        return int'($urandom_range(0, 2 * DEC_MAX)) - DEC_MAX;
    endfunction

    function automatic int rand_ra();
        return int'($urandom_range(0, RA_MAX));
    endfunction

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_lookup_out entry_hit(int i, int eff);
        t_lookup_out r;
        r = '0;
        r.hit = 1'b1;
        r.ra  = sched_ra[i];
        r.dec = sched_dec[i];
        r.eff = eff;
        return r;
    endfunction

    function automatic void apply_config(logic [tisl_pkg::CFG_IDX_W-1:0] idx,
                                         logic [31:0] data);
        case (idx)
            tisl_pkg::CFG_SKIP_AGE:     cfg_skip_age = data[tisl_pkg::AGE_W-1:0];
            tisl_pkg::CFG_EARLY_MARGIN: cfg_early_margin = data[tisl_pkg::AGE_W-1:0];
            tisl_pkg::CFG_FIXED_MODE:   cfg_fixed_mode = data[0];
            tisl_pkg::CFG_FIXED_RA:     cfg_fixed_ra = data[tisl_pkg::RA_W-1:0];
            tisl_pkg::CFG_FIXED_DEC:    cfg_fixed_dec = data[tisl_pkg::DEC_W-1:0];
            default: ;
        endcase
    endfunction

    // advances the predicted table by one command and returns its result item
    function automatic t_lookup_out apply_command(logic [1:0] cmd, int t,
                                                  logic [tisl_pkg::RA_W-1:0] ra,
                                                  logic [tisl_pkg::DEC_W-1:0] dec, int now);
        t_lookup_out r;
        int          n;
        int          i;
        longint      s;
        longint      e;
        bit          found;
        r = '0;
        n = sched_count;
        found = 1'b0;
        case (cmd)
            tisl_pkg::CMD_CLEAR: sched_count = 0;
            tisl_pkg::CMD_APPEND: begin
                if (cfg_skip_age != 0 &&
                    longint'(now) - longint'(t) > longint'(cfg_skip_age)) begin
                    r.status = tisl_pkg::ST_TOO_OLD;
                end else begin
                    // previous entry gets closed even if this record is refused
                    if (n > 0) sched_end[n-1] = t;
                    if (t <= 0) begin
                        r.status = tisl_pkg::ST_NONPOS;
                    end else if (n >= tisl_pkg::TABLE_DEPTH) begin
                        r.status = tisl_pkg::ST_FULL;
                    end else begin
                        sched_start[n] = t;
                        sched_end[n]   = 0;
                        sched_ra[n]    = ra;
                        sched_dec[n]   = dec;
                        sched_count    = n + 1;
                    end
                end
            end
            tisl_pkg::CMD_FINISH: begin
                if (n > 0) begin
                    r.hit = 1'b1;
                    if (sched_end[n-1] < tisl_pkg::OPEN_END_LIMIT) begin
                        e = longint'(sched_start[n-1]) + tisl_pkg::ONE_DAY;
                        if (e > longint'(tisl_pkg::TIME_MAX)) e = longint'(tisl_pkg::TIME_MAX);
                        sched_end[n-1] = int'(e);
                    end
                end
            end
            default: begin
                if (cfg_fixed_mode) begin
                    r.hit = 1'b1;
                    r.ra  = cfg_fixed_ra;
                    r.dec = cfg_fixed_dec;
                    r.eff = t;
                end else begin
                    // newest first: containment with early margin, then the gap after it
                    for (int k = n; k > 0 && !found; k--) begin
                        i = k - 1;
                        s = sched_start[i];
                        e = sched_end[i];
                        if (longint'(t) >= s - longint'(cfg_early_margin) &&
                            longint'(t) <= e) begin
                            r = entry_hit(i, t);
                            found = 1'b1;
                        end else if (i + 1 < n && longint'(t) >= e &&
                                     t <= sched_start[i+1]) begin
                            r = entry_hit(i + 1, t);
                            found = 1'b1;
                        end
                    end
                    if (!found && n > 0) begin
                        if (t < sched_start[0]) r = entry_hit(0, sched_start[0]);
                        // after-last wins over before-first
                        if (t > sched_start[n-1]) r = entry_hit(n - 1, sched_start[n-1]);
                    end
                end
            end
        endcase
        r.held = tisl_pkg::CNT_W'(sched_count);
        return r;
    endfunction

    function automatic void add_row(logic [1:0] cmd, int t, int ra, int dec, int now,
                                    bit typed, logic hit, logic [1:0] status, int held);
        t_plan_row p;
        p.cmd = cmd; p.t = t; p.ra = ra; p.dec = dec; p.now = now;
        p.typed = typed; p.hit = hit; p.status = status; p.held = held;
        directed_plan.insert(directed_plan.size(), p);
    endfunction

    function automatic int pick_query_time();
        int     j;
        longint base;
        if (sched_count == 0) return int'($urandom);
        j = $urandom_range(0, sched_count - 1);
        base = sched_start[j];
        case ($urandom_range(0, 9))
            0: return sat32(base - longint'(cfg_early_margin));
            1: return sat32(base - longint'(cfg_early_margin) - 1);
            2: return sched_end[j];
            3: return sat32(longint'(sched_end[j]) + 1);
            4: return sat32(longint'(sched_start[0]) - int'($urandom_range(1, 1000)));
            5: return sat32(longint'(sched_start[sched_count-1]) +
                            int'($urandom_range(1, 1000)));
            6: return int'($urandom);
            default: return sat32(base + int'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic [31:0] with_junk(logic [31:0] val, int w);
        logic [31:0] mask;
        mask = (32'h1 << w) - 32'h1;
        return ($urandom & ~mask) | (val & mask);
    endfunction

    task automatic send(input logic [1:0] cmd, input int t, input int ra, input int dec,
                        input int now, input bit typed = 1'b0,
                        input t_lookup_out typed_exp = '0);
        int gap;
        gap = pick_gap(in_quiet);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_event_time   <= t;
        i_position_ra  <= ra[tisl_pkg::RA_W-1:0];
        i_position_dec <= dec[tisl_pkg::DEC_W-1:0];
        i_current_time <= now;
        drv_typed = typed;
        drv_exp   = typed_exp;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [tisl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_config(input int phase);
        logic [31:0] age;
        logic [31:0] margin;
        logic [31:0] ra;
        logic [31:0] dec;
        logic [31:0] mode;
        if (phase == 0) begin
            age = 0; margin = 32'h7FFF_FFFF; mode = 1; ra = RA_MAX; dec = -DEC_MAX;
        end else if (phase == 1) begin
            age = 32'h7FFF_FFFF; margin = 0; mode = 0; ra = 0; dec = DEC_MAX;
        end else begin
            case ($urandom_range(0, 5))
                0: age = 0;
                1: age = 32'h7FFF_FFFF;
                2: age = $urandom_range(1, 1000);
                3, 4: age = tisl_pkg::SKIP_AGE_RESET;
                default: age = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0, 1, 2: margin = 0;
                3: margin = 32'h7FFF_FFFF;
                4: margin = $urandom_range(1, 100);
                default: margin = $urandom_range(1, 100000);
            endcase
            mode = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0: ra = 0;
                1: ra = RA_MAX;
                default: ra = rand_ra();
            endcase
            case ($urandom_range(0, 3))
                0: dec = -DEC_MAX;
                1: dec = DEC_MAX;
                default: dec = rand_dec();
            endcase
        end
        // bits above each register's width are junk and must be dropped
        write_reg(tisl_pkg::CFG_SKIP_AGE, with_junk(age, tisl_pkg::AGE_W));
        write_reg(tisl_pkg::CFG_EARLY_MARGIN, with_junk(margin, tisl_pkg::AGE_W));
        write_reg(tisl_pkg::CFG_FIXED_MODE, with_junk(mode, 1));
        write_reg(tisl_pkg::CFG_FIXED_RA, with_junk(ra, tisl_pkg::RA_W));
        write_reg(tisl_pkg::CFG_FIXED_DEC, with_junk(dec, tisl_pkg::DEC_W));
    endtask

    task automatic run_phase(input int phase);
        int     n_rec;
        int     n_q;
        int     t;
        int     now;
        longint cur;
        longint age;
        settle();
        program_config(phase);
        in_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(5, 30))
                send(2'($urandom_range(0, 3)), int'($urandom), rand_ra(), rand_dec(),
                     int'($urandom));
        end else begin
            if ($urandom_range(0, 3) != 0 || sched_count == 0)
                send(tisl_pkg::CMD_CLEAR, int'($urandom), rand_ra(), rand_dec(),
                     int'($urandom));
            if (phase % 20 == 3) n_rec = tisl_pkg::TABLE_DEPTH + $urandom_range(1, 4);
            else if ($urandom_range(0, 11) == 0) n_rec = $urandom_range(40, 120);
            else n_rec = $urandom_range(1, 24);
            if (sched_count > 0) cur = sched_start[sched_count-1];
            else if ($urandom_range(0, 7) == 0) cur = 64'sd2147483647 - 200000;
            else cur = $urandom_range(1, 1000000);
            age = cfg_skip_age;
            repeat (n_rec) begin
                if ($urandom_range(0, 9) == 0) cur = cur - $urandom_range(0, 5000);
                else if ($urandom_range(0, 3) == 0) cur = cur + $urandom_range(0, 10);
                else cur = cur + $urandom_range(10, 100000);
                t = sat32(cur);
                if ($urandom_range(0, 14) == 0) t = -int'($urandom_range(0, 1000));
                case ($urandom_range(0, 9))
                    0: now = sat32(t + age + 1 + $urandom_range(0, 50));
                    1: now = sat32(t + age);
                    2: now = sat32(longint'(t) - int'($urandom_range(0, 100000)));
                    default: now = sat32(longint'(t) + int'($urandom_range(0, 100)));
                endcase
                send(tisl_pkg::CMD_APPEND, t, rand_ra(), rand_dec(), now);
            end
            if ($urandom_range(0, 4) != 0)
                send(tisl_pkg::CMD_FINISH, int'($urandom), rand_ra(), rand_dec(),
                     int'($urandom));
            n_q = (n_rec > 100) ? $urandom_range(3, 8) : $urandom_range(3, 20);
            repeat (n_q) begin
                if ($urandom_range(0, 19) == 0)
                    send(tisl_pkg::CMD_FINISH, int'($urandom), rand_ra(), rand_dec(),
                         int'($urandom));
                else
                    send(tisl_pkg::CMD_QUERY, pick_query_time(), rand_ra(), rand_dec(),
                         int'($urandom));
            end
        end
    endtask

    // receiver stall: runs of no stall, light stall and heavy stall
    initial begin : out_stall_gen
        int stall_left;
        int mode;
        int mode_left;
        stall_left = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(50, 600);
                end else begin
                    mode_left--;
                end
                case (mode)
                    0: stall_left = 0;
                    1: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                    default: stall_left = pick_gap(1'b0);
                endcase
            end
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_lookup_out got;
        t_lookup_out want;
        t_lookup_out pred;
        bit          progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                progress = 1'b1;
                got.hit = o_hit;
                got.ra = o_result_ra;
                got.dec = o_result_dec;
                got.eff = o_effective_time;
                got.status = o_load_status;
                got.held = o_entries_held;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result item, nothing pending", $realtime);
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit || got.ra !== want.ra ||
                        got.dec !== want.dec || got.eff !== want.eff ||
                        got.status !== want.status || got.held !== want.held) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: result mismatch (expected / actual)", $realtime);
                            $display("  hit %0b/%0b ra %0d/%0d dec %0d/%0d",
                                     want.hit, got.hit, want.ra, got.ra,
                                     $signed(want.dec), $signed(got.dec));
                            $display("  eff_time %0d/%0d status %0d/%0d held %0d/%0d",
                                     $signed(want.eff), $signed(got.eff),
                                     want.status, got.status, want.held, got.held);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                progress = 1'b1;
                pred = apply_command(i_command, i_event_time, i_position_ra,
                                     i_position_dec, i_current_time);
                pending_results.insert(pending_results.size(), drv_typed ? drv_exp : pred);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                progress = 1'b1;
                apply_config(i_cfg_index, i_cfg_data);
            end
        end
        if (progress || !i_rst_n) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without progress", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        t_lookup_out exp;
        int          phase;
        // after reset: skip age one day, margin zero, no fixed target
        add_row(tisl_pkg::CMD_QUERY,  100, 0, 0, 0, 1'b1, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_FINISH, 0, 0, 0, 0, 1'b1, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_APPEND, 0, 5, 5, 0, 1'b1, 1'b0, tisl_pkg::ST_NONPOS, 0);
        add_row(tisl_pkg::CMD_APPEND, 32'sh8000_0000, RA_MAX, -DEC_MAX, 32'sh8000_0000,
                1'b1, 1'b0, tisl_pkg::ST_NONPOS, 0);
        add_row(tisl_pkg::CMD_APPEND, 1000, 7, 7, 1000000000,
                1'b1, 1'b0, tisl_pkg::ST_TOO_OLD, 0);
        add_row(tisl_pkg::CMD_APPEND, 1000, 0, -DEC_MAX, 1000,
                1'b1, 1'b0, tisl_pkg::ST_STORED, 1);
        add_row(tisl_pkg::CMD_APPEND, 2000, RA_MAX, DEC_MAX, 2000,
                1'b1, 1'b0, tisl_pkg::ST_STORED, 2);
        add_row(tisl_pkg::CMD_QUERY,  1500, 0, 0, 0, 1'b0, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_QUERY,  32'sh7FFF_FFFF, 0, 0, 0,
                1'b0, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_QUERY,  32'sh8000_0000, 0, 0, 0,
                1'b0, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_QUERY,  2000, 0, 0, 0, 1'b0, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_FINISH, 0, 0, 0, 0, 1'b1, 1'b1, tisl_pkg::ST_STORED, 2);
        add_row(tisl_pkg::CMD_QUERY,  50000, 0, 0, 0, 1'b0, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_APPEND, 32'sh7FFF_FFFF, 12345, -1, 0,
                1'b1, 1'b0, tisl_pkg::ST_STORED, 3);
        // open end of a start at the top of the range saturates
        add_row(tisl_pkg::CMD_FINISH, 0, 0, 0, 0, 1'b1, 1'b1, tisl_pkg::ST_STORED, 3);
        add_row(tisl_pkg::CMD_QUERY,  32'sh7FFF_FFFF, 0, 0, 0,
                1'b0, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_APPEND, -5, 1, 1, -5, 1'b1, 1'b0, tisl_pkg::ST_NONPOS, 3);
        add_row(tisl_pkg::CMD_APPEND, 1, 1, 1, 32'sh7FFF_FFFF,
                1'b1, 1'b0, tisl_pkg::ST_TOO_OLD, 3);
        add_row(tisl_pkg::CMD_QUERY,  3000, 0, 0, 0, 1'b0, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_CLEAR,  0, 0, 0, 0, 1'b1, 1'b0, tisl_pkg::ST_STORED, 0);
        // starts out of order: before-first and after-last both apply
        add_row(tisl_pkg::CMD_APPEND, 5000, 111, 222, 5000,
                1'b1, 1'b0, tisl_pkg::ST_STORED, 1);
        add_row(tisl_pkg::CMD_APPEND, 3000, 333, -444, 3000,
                1'b1, 1'b0, tisl_pkg::ST_STORED, 2);
        add_row(tisl_pkg::CMD_QUERY,  4000, 0, 0, 0, 1'b0, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_QUERY,  6000, 0, 0, 0, 1'b0, 1'b0, tisl_pkg::ST_STORED, 0);
        add_row(tisl_pkg::CMD_CLEAR,  0, 0, 0, 0, 1'b1, 1'b0, tisl_pkg::ST_STORED, 0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k]) begin
            exp = '0;
            exp.hit = directed_plan[k].hit;
            exp.status = directed_plan[k].status;
            exp.held = tisl_pkg::CNT_W'(directed_plan[k].held);
            send(directed_plan[k].cmd, directed_plan[k].t, directed_plan[k].ra,
                 directed_plan[k].dec, directed_plan[k].now, directed_plan[k].typed, exp);
        end

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            run_phase(phase);
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
